>>> sv/hmh_pkg.sv
package hmh_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CH_W      = IDX_W + 2;
    localparam int KEY_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [STAT_W-1:0]       stat_t;

    // One write and two reads per cycle on the heap array.
    typedef struct packed {
        logic we;
        idx_t waddr;
        key_t wdata;
        idx_t raddr_a;
        idx_t raddr_b;
    } mem_req_t;

    typedef struct packed {
        stat_t status;
        cnt_t  count;
        key_t  root;
    } res_t;

endpackage

>>> sv/hmh_req_if.sv
interface hmh_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    hmh_pkg::key_t value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

>>> sv/hmh_rsp_if.sv
interface hmh_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [hmh_pkg::STAT_W-1:0]          status;
    logic [hmh_pkg::CNT_OUT_W-1:0]       count;
    logic                                top_valid;
    hmh_pkg::key_t                       top_value;

    modport source (output valid, output status, output count, output top_valid,
                    output top_value, input ready);
    modport sink (input valid, input status, input count, input top_valid,
                  input top_value, output ready);
endinterface

>>> sv/min_heap_insert_delete_by_value.sv
// Binary min-heap of signed 32-bit keys held in one synchronous RAM with a
// registered read. Each request beat is an insert or a delete of the first
// entry equal to the key, and each yields exactly one response beat with a
// status, the entry count and the current minimum. An insert sifts the key up
// from the new last slot, one level at a time. A delete scans the array one
// entry per cycle until it finds the key or runs out of entries; unless the
// match was the last entry, the last entry then fills the freed slot and sifts
// down or up level by level. Each sift step reads, compares and writes on the
// single RAM. A finished response waits in an output register, so the next
// request is taken while it is still unread.
module min_heap_insert_delete_by_value (
    input  logic     clk,
    input  logic     rst_n,
    hmh_req_if.sink  req,
    hmh_rsp_if.source rsp
);
    import hmh_pkg::*;

    mem_req_t mreq;
    key_t     rdata_a;
    key_t     rdata_b;
    logic     res_valid;
    logic     res_ready;
    res_t     res;

    logic                 rsp_valid_reg;
    stat_t                status_reg;
    logic [CNT_OUT_W-1:0] count_reg;
    logic                 top_valid_reg;
    key_t                 top_value_reg;
    logic                 nonempty;

    hmh_mem u_mem (
        .clk     (clk),
        .mreq    (mreq),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    hmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mreq      (mreq),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !rsp_valid_reg || rsp.ready;
    assign nonempty  = (res.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            status_reg    <= res.status;
            count_reg     <= CNT_OUT_W'(res.count);
            top_valid_reg <= nonempty;
            top_value_reg <= nonempty ? res.root : '0;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.count     = count_reg;
    assign rsp.top_valid = top_valid_reg;
    assign rsp.top_value = top_value_reg;

endmodule

>>> sv/hmh_mem.sv
module hmh_mem (
    input  logic              clk,
    input  hmh_pkg::mem_req_t mreq,
    output hmh_pkg::key_t     rdata_a,
    output hmh_pkg::key_t     rdata_b
);
    import hmh_pkg::*;

    key_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr] <= mreq.wdata;
        end
        rdata_a <= mem[mreq.raddr_a];
        rdata_b <= mem[mreq.raddr_b];
    end

endmodule

>>> sv/hmh_ctrl.sv
module hmh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    hmh_req_if.sink           req,
    output hmh_pkg::mem_req_t mreq,
    input  hmh_pkg::key_t     rdata_a,
    input  hmh_pkg::key_t     rdata_b,
    output logic              res_valid,
    input  logic              res_ready,
    output hmh_pkg::res_t     res
);
    import hmh_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UP    = 3'd1;
    localparam logic [2:0] S_UPC   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_LASTD = 3'd4;
    localparam logic [2:0] S_DN    = 3'd5;
    localparam logic [2:0] S_DNC   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;
    cnt_t       scan_reg, scan_next;
    idx_t       hole_reg, hole_next;
    idx_t       slot_reg, slot_next;
    idx_t       pend_idx_reg, pend_idx_next;
    logic       pend_vld_reg, pend_vld_next;
    logic       moved_reg, moved_next;
    stat_t      status_reg, status_next;
    key_t       mov_reg, mov_next;
    key_t       root_reg;

    logic [CH_W-1:0] lch;
    logic [CH_W-1:0] rch;
    logic [CH_W-1:0] cnt_ext;
    idx_t            hole_m1;
    idx_t            par;
    idx_t            last_idx;
    logic            use_l;
    logic            use_r;
    key_t            lval;

    assign lch      = CH_W'({hole_reg, 1'b0}) + CH_W'(1);
    assign rch      = lch + CH_W'(1);
    assign cnt_ext  = CH_W'(cnt_reg);
    assign hole_m1  = hole_reg - idx_t'(1);
    assign par      = hole_m1 >> 1;
    assign last_idx = idx_t'(cnt_reg - cnt_t'(1));
    assign use_l    = (rdata_a < mov_reg);
    assign lval     = use_l ? rdata_a : mov_reg;
    assign use_r    = (rch < cnt_ext) && (rdata_b < lval);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        scan_next     = scan_reg;
        hole_next     = hole_reg;
        slot_next     = slot_reg;
        pend_idx_next = pend_idx_reg;
        pend_vld_next = pend_vld_reg;
        moved_next    = moved_reg;
        status_next   = status_reg;
        mov_next      = mov_reg;
        mreq.we       = 1'b0;
        mreq.waddr    = hole_reg;
        mreq.wdata    = mov_reg;
        mreq.raddr_a  = par;
        mreq.raddr_b  = rch[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mov_next    = req.value;
                    status_next = ST_DONE;
                    moved_next  = 1'b0;
                    if (req.func == FUNC_INSERT)
                    begin
                        if (cnt_reg == cnt_t'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            hole_next  = cnt_reg[IDX_W-1:0];
                            cnt_next   = cnt_reg + cnt_t'(1);
                            state_next = S_UP;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        scan_next     = '0;
                        pend_vld_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end

            // The moving key stays in mov_reg; parents shift down into the hole.
            S_UP:
            begin
                if (hole_reg == '0)
                begin
                    mreq.we    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mreq.raddr_a = par;
                    state_next   = S_UPC;
                end
            end

            S_UPC:
            begin
                mreq.we = 1'b1;
                if (mov_reg < rdata_a)
                begin
                    mreq.wdata = rdata_a;
                    hole_next  = par;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Reads are issued one per cycle; each is checked in the following cycle.
            S_SCAN:
            begin
                if (pend_vld_reg && (rdata_a == mov_reg))
                begin
                    slot_next    = pend_idx_reg;
                    mreq.raddr_a = last_idx;
                    cnt_next     = cnt_reg - cnt_t'(1);
                    state_next   = S_LASTD;
                end
                else if (scan_reg < cnt_reg)
                begin
                    mreq.raddr_a  = scan_reg[IDX_W-1:0];
                    pend_vld_next = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + cnt_t'(1);
                end
                else if (!pend_vld_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    pend_vld_next = 1'b0;
                end
            end

            S_LASTD:
            begin
                mov_next = rdata_a;
                if (cnt_t'(slot_reg) == cnt_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    hole_next  = slot_reg;
                    state_next = S_DN;
                end
            end

            S_DN:
            begin
                if (lch >= cnt_ext)
                begin
                    if (moved_reg)
                    begin
                        mreq.we    = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_UP;
                    end
                end
                else
                begin
                    mreq.raddr_a = lch[IDX_W-1:0];
                    mreq.raddr_b = rch[IDX_W-1:0];
                    state_next   = S_DNC;
                end
            end

            // If the key moved down, the slot now holds a former child, which
            // cannot be below its parent, so only an unmoved key sifts up.
            S_DNC:
            begin
                if (use_r)
                begin
                    mreq.we    = 1'b1;
                    mreq.wdata = rdata_b;
                    hole_next  = rch[IDX_W-1:0];
                    moved_next = 1'b1;
                    state_next = S_DN;
                end
                else if (use_l)
                begin
                    mreq.we    = 1'b1;
                    mreq.wdata = rdata_a;
                    hole_next  = lch[IDX_W-1:0];
                    moved_next = 1'b1;
                    state_next = S_DN;
                end
                else if (moved_reg)
                begin
                    mreq.we    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            moved_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
            moved_reg    <= moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        hole_reg     <= hole_next;
        slot_reg     <= slot_next;
        pend_idx_reg <= pend_idx_next;
        status_reg   <= status_next;
        mov_reg      <= mov_next;
        // Shadow of entry zero so the minimum is always at hand.
        if (mreq.we && (mreq.waddr == '0))
        begin
            root_reg <= mreq.wdata;
        end
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.count  = cnt_reg;
    assign res.root   = root_reg;

endmodule
